// ===== hw/rtl/dtq_pkg.sv =====
`timescale 1ns / 1ps

package dtq_pkg;

    localparam int TIME_BITS   = 48;
    localparam int TAG_BITS    = 16;
    localparam int HANDLE_BITS = 5;
    localparam int SLOT_BITS   = 5;

    localparam logic [1:0] ACT_SUBMIT   = 2'd0;
    localparam logic [1:0] ACT_CANCEL   = 2'd1;
    localparam logic [1:0] ACT_TICK     = 2'd2;
    localparam logic [1:0] ACT_SHUTDOWN = 2'd3;

    localparam logic [1:0] KIND_ACCEPTED = 2'd0;
    localparam logic [1:0] KIND_FULL     = 2'd1;
    localparam logic [1:0] KIND_FIRED    = 2'd2;
    localparam logic [1:0] KIND_ABORTED  = 2'd3;

    typedef struct packed {
        logic [1:0]             action;
        logic [TIME_BITS-1:0]   deadline;
        logic [TAG_BITS-1:0]    tag;
        logic [HANDLE_BITS-1:0] handle;
        logic [TIME_BITS-1:0]   now_time;
    } t_item;

    typedef struct packed {
        logic [1:0]           kind;
        logic [SLOT_BITS-1:0] slot;
        logic [TAG_BITS-1:0]  owner_tag;
        logic                 last;
    } t_result;

    typedef struct packed {
        logic exec_submit;
        logic exec_cancel;
        logic scan_start;
        logic scan_run;
        logic decide;
    } t_ctl_cmd;

    typedef struct packed {
        logic scan_done;
        logic have_best;
        logic stopped;
    } t_ctl_sts;

endpackage

// ===== hw/rtl/dtq_ram.sv =====
`timescale 1ns / 1ps

module dtq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/dtq_ctrl.sv =====
`timescale 1ns / 1ps

module dtq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_action,
    input  dtq_pkg::t_ctl_sts i_sts,
    output dtq_pkg::t_ctl_cmd o_cmd,
    output logic              o_busy
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_DECIDE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    unique case (i_action)
                        dtq_pkg::ACT_SUBMIT: begin
                            o_cmd.exec_submit = 1'b1;
                        end
                        dtq_pkg::ACT_CANCEL: begin
                            o_cmd.exec_cancel = 1'b1;
                        end
                        dtq_pkg::ACT_TICK: begin
                            // a tick after shutdown has nothing to fire
                            if (!i_sts.stopped) begin
                                o_cmd.scan_start = 1'b1;
                                n_state          = ST_SCAN;
                            end
                        end
                        dtq_pkg::ACT_SHUTDOWN: begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = i_sts.have_best ? ST_SCAN : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// ===== hw/rtl/dtq_datapath.sv =====
`timescale 1ns / 1ps

module dtq_datapath #(
    parameter int SLOTS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dtq_pkg::t_item    i_item,
    input  dtq_pkg::t_ctl_cmd i_cmd,
    output dtq_pkg::t_ctl_sts o_sts,
    output logic              o_result_valid,
    output dtq_pkg::t_result  o_result
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = IW + 1;
    localparam int DW = dtq_pkg::TIME_BITS + dtq_pkg::TAG_BITS;

    logic [SLOTS-1:0]              r_live;
    logic                          r_stopped;
    logic [1:0]                    r_kind;
    logic                          r_bounded;
    logic [dtq_pkg::TIME_BITS-1:0] r_limit;
    logic [CW-1:0]                 r_addr;
    logic                          r_rd_vld;
    logic [IW-1:0]                 r_rd_idx;
    logic                          r_have_best;
    logic [dtq_pkg::TIME_BITS-1:0] r_best_dl;
    logic [IW-1:0]                 r_best_idx;
    logic [dtq_pkg::TAG_BITS-1:0]  r_best_tag;
    logic                          r_pend_vld;
    logic [IW-1:0]                 r_pend_idx;
    logic [dtq_pkg::TAG_BITS-1:0]  r_pend_tag;
    logic                          r_out_vld;
    dtq_pkg::t_result              r_out;

    logic                          free_found;
    logic [IW-1:0]                 free_idx;
    logic [6:0]                    handle_ext;
    logic                          handle_ok;
    logic [IW-1:0]                 handle_idx;
    logic                          wr_en;
    logic                          rd_en;
    logic [DW-1:0]                 rd_data;
    logic [dtq_pkg::TIME_BITS-1:0] rd_dl;
    logic [dtq_pkg::TAG_BITS-1:0]  rd_tag;
    logic                          cand;

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_live[i]) begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    assign handle_ext = 7'(i_item.handle);
    assign handle_ok  = (handle_ext < 7'(SLOTS));
    assign handle_idx = IW'(handle_ext);

    assign wr_en = i_cmd.exec_submit && !r_stopped && free_found;
    assign rd_en = i_cmd.scan_run && (r_addr < CW'(SLOTS));

    dtq_ram #(
        .WIDTH (DW),
        .DEPTH (SLOTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (free_idx),
        .i_wr_data ({i_item.deadline, i_item.tag}),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr[IW-1:0]),
        .o_rd_data (rd_data)
    );

    assign rd_dl  = rd_data[DW-1:dtq_pkg::TAG_BITS];
    assign rd_tag = rd_data[dtq_pkg::TAG_BITS-1:0];

    // strict less-than over ascending slots keeps the lower handle on ties
    assign cand = r_rd_vld && r_live[r_rd_idx]
                  && (!r_bounded || (rd_dl <= r_limit))
                  && (!r_have_best || (rd_dl < r_best_dl));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live      <= '0;
            r_stopped   <= 1'b0;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_have_best <= 1'b0;
            r_pend_vld  <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.exec_submit || (i_cmd.decide && r_pend_vld);

            if (i_cmd.exec_submit) begin
                r_out.last      <= 1'b1;
                r_out.owner_tag <= i_item.tag;
                if (r_stopped) begin
                    r_out.kind <= dtq_pkg::KIND_ABORTED;
                    r_out.slot <= '0;
                end else if (free_found) begin
                    r_live[free_idx] <= 1'b1;
                    r_out.kind       <= dtq_pkg::KIND_ACCEPTED;
                    r_out.slot       <= dtq_pkg::SLOT_BITS'(free_idx);
                end else begin
                    r_out.kind <= dtq_pkg::KIND_FULL;
                    r_out.slot <= '0;
                end
            end

            if (i_cmd.exec_cancel && handle_ok) begin
                r_live[handle_idx] <= 1'b0;
            end

            if (i_cmd.scan_start) begin
                r_bounded   <= (i_item.action != dtq_pkg::ACT_SHUTDOWN);
                r_kind      <= (i_item.action == dtq_pkg::ACT_SHUTDOWN)
                               ? dtq_pkg::KIND_ABORTED : dtq_pkg::KIND_FIRED;
                r_limit     <= i_item.now_time;
                r_addr      <= '0;
                r_rd_vld    <= 1'b0;
                r_have_best <= 1'b0;
                r_pend_vld  <= 1'b0;
                if (i_item.action == dtq_pkg::ACT_SHUTDOWN) begin
                    r_stopped <= 1'b1;
                end
            end

            if (i_cmd.scan_run) begin
                r_rd_vld <= rd_en;
                r_rd_idx <= r_addr[IW-1:0];
                if (rd_en) begin
                    r_addr <= r_addr + CW'(1);
                end
                if (cand) begin
                    r_have_best <= 1'b1;
                    r_best_dl   <= rd_dl;
                    r_best_idx  <= r_rd_idx;
                    r_best_tag  <= rd_tag;
                end
            end

            // results trail the scan by one pass so the final one can carry last
            if (i_cmd.decide) begin
                r_addr      <= '0;
                r_rd_vld    <= 1'b0;
                r_have_best <= 1'b0;
                if (r_pend_vld) begin
                    r_out.kind      <= r_kind;
                    r_out.slot      <= dtq_pkg::SLOT_BITS'(r_pend_idx);
                    r_out.owner_tag <= r_pend_tag;
                    r_out.last      <= !r_have_best;
                end
                if (r_have_best) begin
                    r_live[r_best_idx] <= 1'b0;
                    r_pend_vld         <= 1'b1;
                    r_pend_idx         <= r_best_idx;
                    r_pend_tag         <= r_best_tag;
                end else begin
                    r_pend_vld <= 1'b0;
                end
            end
        end
    end

    assign o_sts.scan_done = r_rd_vld && (r_rd_idx == IW'(SLOTS - 1));
    assign o_sts.have_best = r_have_best;
    assign o_sts.stopped   = r_stopped;

    assign o_result_valid = r_out_vld;
    assign o_result       = r_out;

endmodule

// ===== hw/rtl/deadline_timer_queue_unit.sv =====
`timescale 1ns / 1ps
// submit and cancel: busy stays low, a submit result strobes the cycle after start
// tick and shutdown: each pass reads every slot of the store in order (one read a cycle), then decides
// k results cost k+1 passes, and busy stays high through all of them
// results strobe for one cycle each and cannot be stalled; the last one strobes as busy goes low
// synchronous active-low reset empties every slot and clears the shutdown flag

module deadline_timer_queue_unit #(
    parameter int SLOTS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  dtq_pkg::t_item   i_item,
    output logic             busy,
    output logic             o_result_valid,
    output dtq_pkg::t_result o_result
);

    dtq_pkg::t_ctl_cmd cmd;
    dtq_pkg::t_ctl_sts sts;

    dtq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_item.action),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    dtq_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    a_submit_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.action == dtq_pkg::ACT_SUBMIT)
        |=> (o_result_valid && o_result.last))
        else $error("submit not answered in the next cycle");

    a_cancel_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.action == dtq_pkg::ACT_CANCEL) |=> !o_result_valid)
        else $error("cancel produced a result");

    a_submit_kinds_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.kind == dtq_pkg::KIND_ACCEPTED
                            || o_result.kind == dtq_pkg::KIND_FULL))
        |-> o_result.last)
        else $error("submit answer without last");

    a_scan_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.scan_run || cmd.decide) |-> busy)
        else $error("scan running while idle");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam int NUM_SLOTS   = 32;
    localparam int QUIET_LIMIT = 2000;
    localparam int PASS_CYCLES = NUM_SLOTS + 2;

    // mirror of the timer table and the queue of results still to come
    class timer_table_shadow;
        bit                            live [NUM_SLOTS];
        logic [dtq_pkg::TIME_BITS-1:0] due [NUM_SLOTS];
        logic [dtq_pkg::TAG_BITS-1:0]  owner [NUM_SLOTS];
        bit                            halted;
        dtq_pkg::t_result              awaited[$];
        int                            mismatches;

        function new();
            int i;
            for (i = 0; i < NUM_SLOTS; i++) begin
                live[i]  = 1'b0;
                due[i]   = '0;
                owner[i] = '0;
            end
            halted     = 1'b0;
            mismatches = 0;
        endfunction

        function int earliest_due(input bit bounded,
                                  input logic [dtq_pkg::TIME_BITS-1:0] horizon);
            int i;
            int best;
            best = -1;
            for (i = 0; i < NUM_SLOTS; i++) begin
                if (live[i] && (!bounded || due[i] <= horizon)) begin
                    if (best < 0 || due[i] < due[best])
                        best = i;
                end
            end
            return best;
        endfunction

        // frees every due slot in deadline order, one result each, last flagged
        function void release_due(input logic [1:0] kind, input bit bounded,
                                  input logic [dtq_pkg::TIME_BITS-1:0] horizon);
            int               s;
            dtq_pkg::t_result held;
            bit               have_held;
            have_held = 1'b0;
            held      = '0;
            s = earliest_due(bounded, horizon);
            while (s >= 0) begin
                if (have_held)
                    awaited.push_back(held);
                held.kind      = kind;
                held.slot      = dtq_pkg::SLOT_BITS'(s);
                held.owner_tag = owner[s];
                held.last      = 1'b0;
                have_held      = 1'b1;
                live[s]        = 1'b0;
                s = earliest_due(bounded, horizon);
            end
            if (have_held) begin
                held.last = 1'b1;
                awaited.push_back(held);
            end
        endfunction

        function void note_command(input dtq_pkg::t_item it);
            int               i;
            dtq_pkg::t_result r;
            r = '0;
            case (it.action)
                dtq_pkg::ACT_SUBMIT: begin
                    r.owner_tag = it.tag;
                    r.last      = 1'b1;
                    if (halted) begin
                        r.kind = dtq_pkg::KIND_ABORTED;
                    end else begin
                        for (i = 0; i < NUM_SLOTS && live[i]; i++) begin
                        end
                        if (i < NUM_SLOTS) begin
                            live[i]  = 1'b1;
                            due[i]   = it.deadline;
                            owner[i] = it.tag;
                            r.kind   = dtq_pkg::KIND_ACCEPTED;
                            r.slot   = dtq_pkg::SLOT_BITS'(i);
                        end else begin
                            r.kind = dtq_pkg::KIND_FULL;
                        end
                    end
                    awaited.push_back(r);
                end
                dtq_pkg::ACT_CANCEL: begin
                    if (int'(it.handle) < NUM_SLOTS)
                        live[it.handle] = 1'b0;
                end
                dtq_pkg::ACT_TICK: begin
                    if (!halted)
                        release_due(dtq_pkg::KIND_FIRED, 1'b1, it.now_time);
                end
                default: begin
                    release_due(dtq_pkg::KIND_ABORTED, 1'b0, '0);
                    halted = 1'b1;
                end
            endcase
        endfunction

        function void flag(input string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        function void check_result(input dtq_pkg::t_result got);
            dtq_pkg::t_result want;
            if (awaited.size() == 0) begin
                flag($sformatf("unexpected result: kind %0d slot %0d tag %h last %0b",
                               got.kind, got.slot, got.owner_tag, got.last));
                return;
            end
            want = awaited.pop_front();
            if (got.kind !== want.kind || got.slot !== want.slot ||
                got.owner_tag !== want.owner_tag || got.last !== want.last)
                flag($sformatf({"result mismatch: expected kind %0d slot %0d tag %h last %0b,",
                                " got kind %0d slot %0d tag %h last %0b"},
                               want.kind, want.slot, want.owner_tag, want.last,
                               got.kind, got.slot, got.owner_tag, got.last));
        endfunction
    endclass

    logic             clk   = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    dtq_pkg::t_item   item_q = '0;
    logic             busy;
    logic             o_result_valid;
    dtq_pkg::t_result o_result;

    int                            quiet_cycles = 0;
    logic [dtq_pkg::TIME_BITS-1:0] sim_now = '0;
    logic [dtq_pkg::TIME_BITS-1:0] last_deadline = '0;

    timer_table_shadow timers = new();

    deadline_timer_queue_unit #(
        .SLOTS(NUM_SLOTS)
    ) u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .start         (start),
        .i_item        (item_q),
        .busy          (busy),
        .o_result_valid(o_result_valid),
        .o_result      (o_result)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // results are checked as they strobe; the watchdog counts cycles with no transaction
    always @(posedge clk) begin
        if (rst_n && o_result_valid === 1'b1)
            timers.check_result(o_result);
        if (!rst_n || (start === 1'b1 && busy === 1'b0) || o_result_valid === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [dtq_pkg::TIME_BITS-1:0] rand_time();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[dtq_pkg::TIME_BITS-1:0];
    endfunction

    function automatic dtq_pkg::t_item junk_item();
        dtq_pkg::t_item it;
        it.action   = 2'($urandom());
        it.deadline = rand_time();
        it.tag      = dtq_pkg::TAG_BITS'($urandom());
        it.handle   = dtq_pkg::HANDLE_BITS'($urandom());
        it.now_time = rand_time();
        return it;
    endfunction

    function automatic dtq_pkg::t_item cmd(input logic [1:0] act,
                                           input logic [dtq_pkg::TIME_BITS-1:0] dl,
                                           input logic [dtq_pkg::TAG_BITS-1:0] tg,
                                           input logic [dtq_pkg::HANDLE_BITS-1:0] h,
                                           input logic [dtq_pkg::TIME_BITS-1:0] nw);
        dtq_pkg::t_item it;
        it.action   = act;
        it.deadline = dl;
        it.tag      = tg;
        it.handle   = h;
        it.now_time = nw;
        return it;
    endfunction

    // called at a rising edge; returns at the edge that takes the transaction
    task automatic issue(input dtq_pkg::t_item it);
        start  <= 1'b1;
        item_q <= it;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        timers.note_command(it);
    endtask

    task automatic idle_for(input int pct);
        while ($urandom_range(99, 0) < pct) begin
            start  <= 1'b0;
            item_q <= junk_item();
            @(posedge clk);
        end
    endtask

    // bursts of one flavour: fill the table, mixed churn, or drain by ticks and cancels
    task automatic run_random(input int pct, input int quota);
        int             done;
        int             mode;
        int             len;
        int             roll;
        int             w_sub;
        int             w_can;
        int             h;
        int             k;
        bit             counted;
        dtq_pkg::t_item it;
        done = 0;
        while (done < quota) begin
            mode = $urandom_range(2, 0);
            len  = $urandom_range(40, 12);
            case (mode)
                0: begin
                    w_sub = 85;
                    w_can = 5;
                end
                1: begin
                    w_sub = 45;
                    w_can = 25;
                end
                default: begin
                    w_sub = 15;
                    w_can = 30;
                end
            endcase
            repeat (len) begin
                it   = junk_item();
                roll = $urandom_range(99, 0);
                if (roll < w_sub) begin
                    it.action = dtq_pkg::ACT_SUBMIT;
                    roll = $urandom_range(99, 0);
                    if (mode == 0)
                        it.deadline = sim_now
                                      + dtq_pkg::TIME_BITS'($urandom_range(5000, 1000));
                    else if (roll < 65)
                        it.deadline = sim_now + dtq_pkg::TIME_BITS'($urandom_range(600, 0));
                    else if (roll < 80)
                        it.deadline = last_deadline;
                    else if (roll < 90)
                        it.deadline = rand_time();
                    else if (roll < 95)
                        it.deadline = '0;
                    else
                        it.deadline = '1;
                    last_deadline = it.deadline;
                end else if (roll < w_sub + w_can) begin
                    it.action = dtq_pkg::ACT_CANCEL;
                    if ($urandom_range(99, 0) < 65) begin
                        h = $urandom_range(NUM_SLOTS - 1, 0);
                        for (k = 0; k < NUM_SLOTS && !timers.live[(h + k) % NUM_SLOTS]; k++) begin
                        end
                        if (k < NUM_SLOTS)
                            it.handle = dtq_pkg::HANDLE_BITS'((h + k) % NUM_SLOTS);
                    end
                end else begin
                    it.action = dtq_pkg::ACT_TICK;
                    roll = $urandom_range(99, 0);
                    if (roll < 80) begin
                        sim_now = sim_now
                                  + dtq_pkg::TIME_BITS'($urandom_range(mode == 2 ? 400 : 150, 0));
                        it.now_time = sim_now;
                    end else if (roll < 90) begin
                        it.now_time = rand_time();
                    end else if (roll < 95) begin
                        it.now_time = '1;
                    end else begin
                        it.now_time = '0;
                    end
                end
                // a cancel of a slot that is not live does nothing at all
                counted = (it.action != dtq_pkg::ACT_CANCEL) || timers.live[it.handle];
                idle_for(pct);
                issue(it);
                if (counted)
                    done++;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(cmd(dtq_pkg::ACT_TICK, '0, '0, '0, '0));
        issue(cmd(dtq_pkg::ACT_SUBMIT, '0, 16'h0000, '0, '0));
        issue(cmd(dtq_pkg::ACT_SUBMIT, '1, 16'hFFFF, '1, '0));
        issue(cmd(dtq_pkg::ACT_SUBMIT, 48'd100, 16'h1234, '0, '0));
        issue(cmd(dtq_pkg::ACT_SUBMIT, 48'd100, 16'h5678, '0, '0));
        issue(cmd(dtq_pkg::ACT_SUBMIT, 48'd50, 16'hA5A5, '0, '0));
        issue(cmd(dtq_pkg::ACT_CANCEL, '0, '0, 5'd4, '0));
        issue(cmd(dtq_pkg::ACT_CANCEL, '0, '0, 5'd4, '0));
        issue(cmd(dtq_pkg::ACT_CANCEL, '0, '0, 5'd31, '0));
        issue(cmd(dtq_pkg::ACT_TICK, '0, '0, '0, '0));
        issue(cmd(dtq_pkg::ACT_TICK, '0, '0, '0, 48'd99));
        // equal deadlines go out lower handle first
        issue(cmd(dtq_pkg::ACT_TICK, '0, '0, '0, 48'd100));
        issue(cmd(dtq_pkg::ACT_SUBMIT, 48'd7, 16'h0001, '0, '0));
        issue(cmd(dtq_pkg::ACT_TICK, '0, '0, '0, '1));

        run_random(0, 90);
        run_random(87, 90);
        run_random(25, 90);
        run_random(0, 90);

        // shutdown has no way back, so it closes the run
        issue(cmd(dtq_pkg::ACT_SUBMIT, 48'd500, 16'h0011, '0, '0));
        issue(cmd(dtq_pkg::ACT_SUBMIT, 48'd500, 16'h0022, '0, '0));
        issue(cmd(dtq_pkg::ACT_SUBMIT, 48'd3, 16'h0033, '0, '0));
        issue(cmd(dtq_pkg::ACT_SHUTDOWN, '0, '0, '0, '0));
        issue(cmd(dtq_pkg::ACT_SUBMIT, '0, 16'h0000, '0, '0));
        issue(cmd(dtq_pkg::ACT_SUBMIT, '1, 16'hFFFF, '0, '0));
        issue(cmd(dtq_pkg::ACT_TICK, '0, '0, '0, '1));
        issue(cmd(dtq_pkg::ACT_CANCEL, '0, '0, 5'd0, '0));
        issue(cmd(dtq_pkg::ACT_SHUTDOWN, '0, '0, '0, '0));
        issue(cmd(dtq_pkg::ACT_SUBMIT, 48'h5A5A, 16'h5A5A, '0, '0));
        start <= 1'b0;

        while (timers.awaited.size() != 0)
            @(posedge clk);
        repeat (2 * PASS_CYCLES) @(posedge clk);

        if (timers.mismatches == 0 && timers.awaited.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
